// ===== rtl/pdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared widths, codes and types for the periodic deadline timer.
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int TW        = 32;   // time stamp width
    localparam int DATA_W    = 32;   // config write data width
    localparam int CFG_IDX_W = 3;
    localparam int LIFE_W    = 32;
    localparam int CNT_W     = 16;   // count-mode life bits
    localparam int PASS_W    = 32;
    localparam int TL_W      = 31;
    localparam int MODE_W    = 2;
    localparam int DIV_CNT_W = $clog2(TW);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE     = 3'd4;

    localparam logic [MODE_W-1:0] MODE_ENDLESS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIME    = 2'd2;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic [TW-1:0]     period;
        logic [MODE_W-1:0] mode;
        logic [LIFE_W-1:0] life_start;
        logic              zero_ok;
        logic              pre;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_ELAP,
        S_LIFE,
        S_DONE
    } t_state;

endpackage

// ===== rtl/pdt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_in_if
// Input channel: start or check item with its time stamp.
// ----------------------------------------------------------------------------
interface pdt_in_if;
    import pdt_pkg::*;

    logic          valid;
    logic          ready;
    logic          kind;
    logic [31:0]   now_time;

    modport source (output valid, output kind, output now_time, input ready);
    modport sink   (input valid, input kind, input now_time, output ready);
endinterface

// ===== rtl/pdt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_out_if
// Result channel: fire flags, periods passed, time and life left.
// ----------------------------------------------------------------------------
interface pdt_out_if;
    import pdt_pkg::*;

    logic              valid;
    logic              ready;
    logic              fired;
    logic              last_fire;
    logic              running_now;
    logic [PASS_W-1:0] periods_passed;
    logic [TL_W-1:0]   time_left;
    logic [LIFE_W-1:0] life_remaining;

    modport source (output valid, output fired, output last_fire, output running_now,
                    output periods_passed, output time_left, output life_remaining,
                    input ready);
    modport sink   (input valid, input fired, input last_fire, input running_now,
                    input periods_passed, input time_left, input life_remaining,
                    output ready);
endinterface

// ===== rtl/pdt_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_cfg_regs
// Configuration register file, write only, indexed writes.
// ----------------------------------------------------------------------------
module pdt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdt_pkg::DATA_W-1:0]     i_cfg_wdata,
    output pdt_pkg::t_cfg                  o_cfg
);
    import pdt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD:  r_cfg.period     <= i_cfg_wdata[TW-1:0];
                CFG_MODE:    r_cfg.mode       <= i_cfg_wdata[MODE_W-1:0];
                CFG_LIFE:    r_cfg.life_start <= i_cfg_wdata[LIFE_W-1:0];
                CFG_ZERO_OK: r_cfg.zero_ok    <= i_cfg_wdata[0];
                CFG_PRE:     r_cfg.pre        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pdt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdt_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [pdt_pkg::TW-1:0]  i_dividend,
    input  logic [pdt_pkg::TW-1:0]  i_divisor,
    output logic                    o_done,
    output logic [pdt_pkg::TW-1:0]  o_quo,
    output logic [pdt_pkg::TW-1:0]  o_rem
);
    import pdt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TW-1:0]        r_rem;
    logic [TW-1:0]        r_quo;
    logic [TW-1:0]        r_dsr;

    logic [TW:0]   partial;
    logic [TW+1:0] trial;
    logic          borrow;

    assign partial = {r_rem, r_quo[TW-1]};
    assign trial   = {1'b0, partial} - {2'b00, r_dsr};
    assign borrow  = trial[TW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(TW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= borrow ? partial[TW-1:0] : trial[TW-1:0];
            r_quo <= {r_quo[TW-2:0], ~borrow};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/periodic_deadline_timer.sv =====
`timescale 1ns / 1ps
// Flow: a start item is evaluated and its result registered; a check that finds the
//   timer due with a nonzero period runs the 32-step serial divider before the
//   elapsed and life steps; other checks skip the divider.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; timer stopped, deadline, life and config cleared.
// ----------------------------------------------------------------------------
// periodic_deadline_timer
// One periodic timer channel with wrap-safe due test and whole-period catch-up.
// ----------------------------------------------------------------------------
module periodic_deadline_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pdt_in_if.sink                         i_item,
    pdt_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdt_pkg::DATA_W-1:0]     i_cfg_wdata
);
    import pdt_pkg::*;

    t_state r_state, n_state;
    t_cfg   cfg;

    logic              r_kind;
    logic [TW-1:0]     r_now;
    logic [TW-1:0]     r_deadline;
    logic [LIFE_W-1:0] r_life;
    logic              r_running;
    logic [TW-1:0]     r_late;
    logic [TW:0]       r_elapsed;
    logic              r_fired;
    logic              r_last;
    logic [PASS_W-1:0] r_passed;

    logic              r_o_valid;
    logic              r_o_fired;
    logic              r_o_last;
    logic              r_o_run;
    logic [PASS_W-1:0] r_o_passed;
    logic [TL_W-1:0]   r_o_tl;
    logic [LIFE_W-1:0] r_o_life;

    logic              finite, per_zero, runnable, start_run, eval_fire;
    logic              div_start, div_done, done_ok;
    logic [TW-1:0]     late, start_dl, div_quo, div_rem, d_left;
    logic [LIFE_W-1:0] load_life, new_life;
    logic [LIFE_W+1:0] life_diff;
    logic [TL_W-1:0]   tl;

    pdt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (late),
        .i_divisor  (cfg.period),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // datapath terms
    always_comb begin
        finite    = (cfg.mode == MODE_COUNT) || (cfg.mode == MODE_TIME);
        per_zero  = (cfg.period == '0);
        late      = r_now - r_deadline;
        runnable  = !(per_zero && !cfg.zero_ok) && !(finite && r_life == '0);
        eval_fire = (r_kind == KIND_CHECK) && r_running && runnable && !late[TW-1];

        if (cfg.mode == MODE_COUNT) begin
            load_life = {{(LIFE_W-CNT_W){1'b0}}, cfg.life_start[CNT_W-1:0]};
        end else if (cfg.mode == MODE_TIME) begin
            load_life = cfg.life_start;
        end else begin
            load_life = '0;
        end
        start_run = !(per_zero && !cfg.zero_ok) && !(finite && load_life == '0);

        if (!start_run) begin
            start_dl = '0;
        end else if (cfg.pre && cfg.mode == MODE_TIME) begin
            start_dl = r_now;
        end else if (cfg.pre) begin
            start_dl = r_now - cfg.period;
        end else begin
            start_dl = r_now + cfg.period;
        end

        // time mode: life <= elapsed ends the life
        life_diff = {2'b00, r_life} - {1'b0, r_elapsed};
        if (cfg.mode == MODE_COUNT) begin
            new_life = r_life - 1'b1;
        end else if (cfg.mode == MODE_TIME) begin
            new_life = (life_diff[LIFE_W+1] || life_diff == '0) ? '0 : life_diff[LIFE_W-1:0];
        end else begin
            new_life = r_life;
        end

        d_left  = r_deadline - r_now;
        tl      = (!r_running || d_left[TW-1] || d_left == '0) ? '0 : TL_W'(d_left);
        done_ok = !r_o_valid || o_result.ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_item.valid) n_state = S_EVAL;
            S_EVAL: begin
                if (!eval_fire) n_state = S_DONE;
                else if (per_zero) n_state = S_LIFE;
                else n_state = S_DIV;
            end
            S_DIV:  if (div_done) n_state = S_ELAP;
            S_ELAP: n_state = S_LIFE;
            S_LIFE: n_state = S_DONE;
            S_DONE: if (done_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        div_start    = (r_state == S_EVAL) && eval_fire && !per_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= 1'b0;
            r_deadline <= '0;
            r_life     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && done_ok) begin
                r_o_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_EVAL: begin
                    if (r_kind == KIND_START) begin
                        r_life     <= load_life;
                        r_running  <= start_run;
                        r_deadline <= start_dl;
                    end else if (r_running && !runnable) begin
                        r_running <= 1'b0;
                    end
                end
                S_LIFE: begin
                    r_life     <= new_life;
                    r_deadline <= r_deadline + r_elapsed[TW-1:0];
                    if (finite && new_life == '0) r_running <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    r_kind <= i_item.kind;
                    r_now  <= i_item.now_time[TW-1:0];
                end
                r_fired  <= 1'b0;
                r_last   <= 1'b0;
                r_passed <= '0;
            end
            S_EVAL: begin
                r_late    <= late;
                r_elapsed <= {1'b0, late};      // zero period: elapsed is the lateness
            end
            S_DIV: begin
                if (div_done) begin
                    r_late   <= r_late - div_rem;
                    r_passed <= (&div_quo) ? div_quo : div_quo + 1'b1;
                end
            end
            S_ELAP: r_elapsed <= {1'b0, r_late} + {1'b0, cfg.period};
            S_LIFE: begin
                r_fired <= 1'b1;
                r_last  <= finite && new_life == '0;
            end
            S_DONE: begin
                if (done_ok) begin
                    r_o_fired  <= r_fired;
                    r_o_last   <= r_last;
                    r_o_run    <= r_running;
                    r_o_passed <= r_passed;
                    r_o_tl     <= tl;
                    r_o_life   <= r_life;
                end
            end
            default: ;
        endcase
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.fired          = r_o_fired;
    assign o_result.last_fire      = r_o_last;
    assign o_result.running_now    = r_o_run;
    assign o_result.periods_passed = r_o_passed;
    assign o_result.time_left      = r_o_tl;
    assign o_result.life_remaining = r_o_life;

endmodule

// ===== rtl/pdt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic                        i_fired,
    input  logic                        i_last_fire,
    input  logic                        i_running_now,
    input  logic [pdt_pkg::PASS_W-1:0]  i_periods_passed,
    input  logic [pdt_pkg::TL_W-1:0]    i_time_left
);
    import pdt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped while stalled");

    a_nofire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_fired |-> (i_periods_passed == '0) && !i_last_fire)
        else $error("no fire but periods or last flag set");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_fire |-> i_fired && !i_running_now)
        else $error("last fire left timer armed");

    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_running_now |-> i_time_left == '0)
        else $error("stopped timer reports time left");

endmodule

bind periodic_deadline_timer pdt_checker u_pdt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_result.valid),
    .i_ready          (o_result.ready),
    .i_fired          (o_result.fired),
    .i_last_fire      (o_result.last_fire),
    .i_running_now    (o_result.running_now),
    .i_periods_passed (o_result.periods_passed),
    .i_time_left      (o_result.time_left)
);
